// ===== hw/rtl/pldq_pkg.sv =====
// ----------------------------------------------------------------------------
// pldq_pkg
// Shared types, constants and helpers of the latency delay queue port.
// ----------------------------------------------------------------------------
package pldq_pkg;

   localparam int QUEUE_DEPTH  = 8;
   localparam int HANDLE_WIDTH = 32;
   localparam int CNT_WIDTH    = 4;
   localparam int FILL_WIDTH   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CNT_WIDTH-1:0] INCOMING_DELAY_RESET = CNT_WIDTH'(5);
   localparam logic [CNT_WIDTH-1:0] OUTGOING_DELAY_RESET = CNT_WIDTH'(3);

   typedef enum logic [1:0] {
      MODE_PUSH_IN  = 2'd0,
      MODE_PUSH_OUT = 2'd1,
      MODE_TICK     = 2'd2,
      MODE_POP_IN   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_ACCEPTED  = 3'd0,
      ST_SENT      = 3'd1,
      ST_POPPED    = 3'd2,
      ST_IDLE      = 3'd3,
      ST_NOT_READY = 3'd4,
      ST_NO_REMOTE = 3'd5,
      ST_DROPPED   = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      REG_INCOMING_DELAY   = 2'd0,
      REG_OUTGOING_DELAY   = 2'd1,
      REG_REMOTE_CONNECTED = 2'd2
   } reg_index_type;

   // Operation applied to a whole queue
   typedef struct packed {
      logic push;
      logic pop;
      logic dec;
   } queue_op_type;

   // Per-cell control from the queue
   typedef struct packed {
      logic load;
      logic shift;
      logic dec;
   } cell_ctrl_type;

   function automatic logic [CNT_WIDTH-1:0] dec_sat(input logic [CNT_WIDTH-1:0] cnt);
      dec_sat = (cnt != '0) ? cnt - CNT_WIDTH'(1) : cnt;
   endfunction

endpackage

// ===== hw/rtl/port_latency_delay_queues_unit.sv =====
// ----------------------------------------------------------------------------
// port_latency_delay_queues_unit
// Network port model with an incoming and an outgoing delay queue.
// ----------------------------------------------------------------------------
// Each request (push incoming, push outgoing, tick, pop incoming) produces
// one response in the cycle after it is taken, from a response register, so
// a request can be accepted every cycle while the response side
// keeps up; req_stall rises only while a response is held by rsp_stall. Both
// queues are rows of entry cells that shift toward the head on a removal and
// all count down together on a tick. rsp_incoming_ready and
// rsp_outgoing_count reflect the queue state after the request that produced
// the response. Queue contents need no clearing after reset. Delay and
// remote-connect registers sit on the APB port at byte addresses 0, 4 and 8.
// ----------------------------------------------------------------------------
module port_latency_delay_queues_unit
   import pldq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_payload,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_message,
   output logic        rsp_incoming_ready,
   output logic [3:0]  rsp_outgoing_count,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [CNT_WIDTH-1:0] incoming_delay_ff, incoming_delay_in;
   logic [CNT_WIDTH-1:0] outgoing_delay_ff, outgoing_delay_in;
   logic                 remote_connected_ff, remote_connected_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [HANDLE_WIDTH-1:0] rsp_message_ff, rsp_message_in;

   logic          accept;
   logic          csr_write;
   reg_index_type reg_index;
   mode_type      mode;

   queue_op_type            in_op, out_op;
   logic [HANDLE_WIDTH-1:0] push_msg;
   logic [HANDLE_WIDTH-1:0] in_head_msg, out_head_msg;
   logic                    in_head_ready, out_head_ready;
   logic                    in_full, out_full;
   logic [FILL_WIDTH-1:0]   in_fill, out_fill;

   // ---------------- configuration registers ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign reg_index = reg_index_type'(paddr[3:2]);

   always_comb begin
      incoming_delay_in   = incoming_delay_ff;
      outgoing_delay_in   = outgoing_delay_ff;
      remote_connected_in = remote_connected_ff;
      prdata              = '0;
      unique case (reg_index)
         REG_INCOMING_DELAY: begin
            prdata = 32'(incoming_delay_ff);
            if (csr_write) incoming_delay_in = pwdata[CNT_WIDTH-1:0];
         end
         REG_OUTGOING_DELAY: begin
            prdata = 32'(outgoing_delay_ff);
            if (csr_write) outgoing_delay_in = pwdata[CNT_WIDTH-1:0];
         end
         REG_REMOTE_CONNECTED: begin
            prdata = 32'(remote_connected_ff);
            if (csr_write) remote_connected_in = pwdata[0];
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         incoming_delay_ff   <= INCOMING_DELAY_RESET;
         outgoing_delay_ff   <= OUTGOING_DELAY_RESET;
         remote_connected_ff <= 1'b0;
      end else begin
         incoming_delay_ff   <= incoming_delay_in;
         outgoing_delay_ff   <= outgoing_delay_in;
         remote_connected_ff <= remote_connected_in;
      end
   end

   // ---------------- request decode ----------------
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign mode      = mode_type'(req_mode);
   assign push_msg  = HANDLE_WIDTH'(req_payload);

   always_comb begin
      in_op          = '0;
      out_op         = '0;
      rsp_status_in  = rsp_status_ff;
      rsp_message_in = rsp_message_ff;
      if (accept) begin
         rsp_message_in = '0;
         unique case (mode)
            MODE_PUSH_IN: begin
               if (in_full) begin
                  rsp_status_in = ST_DROPPED;
               end else begin
                  in_op.push    = 1'b1;
                  rsp_status_in = ST_ACCEPTED;
               end
            end
            MODE_PUSH_OUT: begin
               if (out_full) begin
                  rsp_status_in = ST_DROPPED;
               end else begin
                  out_op.push   = 1'b1;
                  rsp_status_in = ST_ACCEPTED;
               end
            end
            MODE_TICK: begin
               in_op.dec     = 1'b1;
               out_op.dec    = 1'b1;
               rsp_status_in = ST_IDLE;
               if (out_head_ready) begin
                  if (remote_connected_ff) begin
                     // send the head, the rest shift and count down
                     out_op.pop     = 1'b1;
                     rsp_message_in = out_head_msg;
                     rsp_status_in  = ST_SENT;
                  end else begin
                     rsp_status_in = ST_NO_REMOTE;
                  end
               end
            end
            MODE_POP_IN: begin
               if (in_head_ready) begin
                  in_op.pop      = 1'b1;
                  rsp_message_in = in_head_msg;
                  rsp_status_in  = ST_POPPED;
               end else begin
                  rsp_status_in = ST_NOT_READY;
               end
            end
            default: begin
               rsp_status_in = ST_NOT_READY;
            end
         endcase
      end
   end

   // ---------------- queues ----------------
   pldq_queue u_incoming (
      .clock      (clock),
      .reset      (reset),
      .op         (in_op),
      .push_msg   (push_msg),
      .push_delay (incoming_delay_ff),
      .head_msg   (in_head_msg),
      .head_ready (in_head_ready),
      .full       (in_full),
      .fill       (in_fill)
   );

   pldq_queue u_outgoing (
      .clock      (clock),
      .reset      (reset),
      .op         (out_op),
      .push_msg   (push_msg),
      .push_delay (outgoing_delay_ff),
      .head_msg   (out_head_msg),
      .head_ready (out_head_ready),
      .full       (out_full),
      .fill       (out_fill)
   );

   // ---------------- response register ----------------
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_message_ff <= rsp_message_in;
   end

   // queue state only moves on a transfer, so it matches the held response
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_message        = 32'(rsp_message_ff);
   assign rsp_incoming_ready = in_head_ready;
   assign rsp_outgoing_count = 4'(out_fill);

   // incoming fill is only used through the head and full flags
   logic unused_in_fill;
   assign unused_in_fill = ^in_fill;

endmodule

// ===== hw/rtl/pldq_cell.sv =====
// ----------------------------------------------------------------------------
// pldq_cell
// One queue entry: a handle and its countdown. Shifts toward the head on a
// pop, loads on a push aimed at it, and counts down on a tick.
// ----------------------------------------------------------------------------
module pldq_cell
   import pldq_pkg::*;
(
   input  logic                    clock,
   input  cell_ctrl_type           ctrl,
   input  logic [HANDLE_WIDTH-1:0] load_msg,
   input  logic [CNT_WIDTH-1:0]    load_cnt,
   input  logic [HANDLE_WIDTH-1:0] nbr_msg,
   input  logic [CNT_WIDTH-1:0]    nbr_cnt,
   output logic [HANDLE_WIDTH-1:0] msg,
   output logic [CNT_WIDTH-1:0]    cnt
);

   logic [HANDLE_WIDTH-1:0] msg_ff, msg_in;
   logic [CNT_WIDTH-1:0]    cnt_ff, cnt_in;

   always_comb begin
      msg_in = msg_ff;
      cnt_in = cnt_ff;
      if (ctrl.shift) begin
         // take the entry behind us, already counted down on a tick
         msg_in = nbr_msg;
         cnt_in = ctrl.dec ? dec_sat(nbr_cnt) : nbr_cnt;
      end else if (ctrl.load) begin
         msg_in = load_msg;
         cnt_in = load_cnt;
      end else if (ctrl.dec) begin
         cnt_in = dec_sat(cnt_ff);
      end
   end

   always_ff @(posedge clock) begin
      msg_ff <= msg_in;
      cnt_ff <= cnt_in;
   end

   assign msg = msg_ff;
   assign cnt = cnt_ff;

endmodule

// ===== hw/rtl/pldq_queue.sv =====
// ----------------------------------------------------------------------------
// pldq_queue
// Head-first delay queue built from a row of cells plus a fill counter.
// ----------------------------------------------------------------------------
module pldq_queue
   import pldq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  queue_op_type            op,
   input  logic [HANDLE_WIDTH-1:0] push_msg,
   input  logic [CNT_WIDTH-1:0]    push_delay,
   output logic [HANDLE_WIDTH-1:0] head_msg,
   output logic                    head_ready,
   output logic                    full,
   output logic [FILL_WIDTH-1:0]   fill
);

   logic [FILL_WIDTH-1:0]   fill_ff, fill_in;
   logic [HANDLE_WIDTH-1:0] msg_q [QUEUE_DEPTH];
   logic [CNT_WIDTH-1:0]    cnt_q [QUEUE_DEPTH];

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      cell_ctrl_type           ctrl;
      logic [HANDLE_WIDTH-1:0] nbr_msg;
      logic [CNT_WIDTH-1:0]    nbr_cnt;

      assign ctrl.load  = op.push && (fill_ff == FILL_WIDTH'(i));
      assign ctrl.shift = op.pop;
      assign ctrl.dec   = op.dec;

      if (i < QUEUE_DEPTH - 1) begin : g_mid
         assign nbr_msg = msg_q[i+1];
         assign nbr_cnt = cnt_q[i+1];
      end else begin : g_tail
         assign nbr_msg = '0;
         assign nbr_cnt = '0;
      end

      pldq_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .load_msg (push_msg),
         .load_cnt (push_delay),
         .nbr_msg  (nbr_msg),
         .nbr_cnt  (nbr_cnt),
         .msg      (msg_q[i]),
         .cnt      (cnt_q[i])
      );
   end

   always_comb begin
      fill_in = fill_ff;
      if (op.push) begin
         fill_in = fill_ff + FILL_WIDTH'(1);
      end else if (op.pop) begin
         fill_in = fill_ff - FILL_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   assign head_msg   = msg_q[0];
   assign head_ready = (fill_ff != '0) && (cnt_q[0] == '0);
   assign full       = (fill_ff == FILL_WIDTH'(QUEUE_DEPTH));
   assign fill       = fill_ff;

endmodule
